FILE: design/npa_pkg.sv
// npa_pkg: shared constants and codes for the next-fit port allocator.
// Used by the allocator top level, its checkers and the testbench.
package npa_pkg;

  localparam int POOL_SIZE_DEF = 1024;
  localparam int WORD_BITS     = 32;

  localparam logic [15:0] RANGE_LOW_RST  = 16'd10000;
  localparam logic [15:0] RANGE_HIGH_RST = 16'd11023;

  localparam logic CFG_RANGE_LOW  = 1'b0;
  localparam logic CFG_RANGE_HIGH = 1'b1;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [1:0] ST_GRANTED   = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_RELEASED  = 2'd2;

endpackage

FILE: design/npa_ram.sv
// npa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module npa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/npa_word_search.sv
// npa_word_search: finds the lowest free slot of one bitmap word inside an
// offset window [lo, hi). Depends on nothing but its parameters.
module npa_word_search #(
  parameter int WB    = 32,
  parameter int AW    = 5,
  parameter int OFF_W = 10
) (
  input  logic [WB-1:0]      word,
  input  logic [AW-1:0]      widx,
  input  logic [OFF_W:0]     lo,
  input  logic [OFF_W:0]     hi,
  output logic               found,
  output logic [$clog2(WB)-1:0] bit_idx
);

  localparam int BW = $clog2(WB);

  logic [WB-1:0] free;

  always_comb begin
    logic [OFF_W:0] off;
    for (int b = 0; b < WB; b++) begin
      off = {1'b0, widx, BW'(b)};
      free[b] = !word[b] && (off >= lo) && (off < hi);
    end
  end

  always_comb begin
    bit_idx = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (free[b]) begin
        bit_idx = BW'(b);
      end
    end
  end

  assign found = |free;

endmodule

FILE: design/next_fit_port_allocator.sv
// next_fit_port_allocator: top level; used-bitmap RAM, next-fit word scan and
// release read-modify-write. Depends on npa_pkg, npa_ram, npa_word_search.
//
//   channel  | direction | word contents
//   s_axis   | in        | tdata: release_port_number[15:0]; tuser: func
//   m_axis   | out       | tdata: granted_port[15:0]; tuser: status[1:0]
//   cfg      | in        | cfg_index 0 range_low, 1 range_high; cfg_wdata[15:0]
//
// Allocate: S_SCAN reads N bitmap words (1 .. pool/32 + 1, one per cycle),
// then S_ALLOC_WR and S_FINISH; when exhausted S_SCAN goes straight to S_FINISH,
// and an empty pool goes from S_IDLE to S_FINISH. Release inside the pool: read,
// write back, finish; outside, straight to finish. After reset a clearing pass
// zeroes the bitmap, one word per cycle; no word is accepted meanwhile.
// One word in flight; the next is accepted while a result waits on m_axis.
module next_fit_port_allocator #(
  parameter int POOL_SIZE = npa_pkg::POOL_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // release_port_number[15:0]
  input  logic        s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // granted_port[15:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);
  import npa_pkg::*;

  localparam int WB     = (WORD_BITS < (2 ** $clog2(POOL_SIZE))) ?
                          WORD_BITS : (2 ** $clog2(POOL_SIZE));
  localparam int BW     = $clog2(WB);
  localparam int NWORDS = (POOL_SIZE + WB - 1) / WB;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int OFF_W  = AW + BW;
  localparam int SZ_W   = OFF_W + 1;
  localparam logic [15:0] POOL_M1 = 16'(POOL_SIZE - 1);
  localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_REL_RD, S_REL_WR, S_SCAN, S_ALLOC_WR, S_FINISH
  } state_t;

  state_t state;

  logic [15:0] range_low, range_high, search_start;

  logic [AW-1:0]     clr_addr;
  logic [SZ_W-1:0]   size_q;
  logic [OFF_W-1:0]  start_q;
  logic [OFF_W-1:0]  off_q;
  logic [WB-1:0]     wdata_q;
  logic              issuing, pend, iph, pph;
  logic [AW-1:0]     iw, pw;
  logic [1:0]        res_status;
  logic [15:0]       res_port;

  // pool size and start offset from the live registers
  logic [15:0] span, room, m1, m2, ss_rel, port_rel;
  logic        empty, start_in, port_in;
  logic [16:0] size17;

  always_comb begin
    span   = range_high - range_low;
    room   = ~range_low;
    m1     = (span < room) ? span : room;
    m2     = (m1 < POOL_M1) ? m1 : POOL_M1;
    empty  = range_high < range_low;
    size17 = {1'b0, m2} + 17'd1;
    ss_rel   = search_start - range_low;
    start_in = !empty && (search_start >= range_low) && ({1'b0, ss_rel} < size17);
    port_rel = s_axis_tdata - range_low;
    port_in  = !empty && (s_axis_tdata >= range_low) && ({1'b0, port_rel} < size17);
  end

  // scan window
  logic [SZ_W-1:0]  size_m1, start_m1;
  logic [AW-1:0]    last_a, last_b, iw_last;
  logic [SZ_W-1:0]  win_lo, win_hi;
  logic             found;
  logic [BW-1:0]    bit_idx;
  logic [WB-1:0]    rdata;

  always_comb begin
    size_m1  = size_q - SZ_W'(1);
    start_m1 = {1'b0, start_q} - SZ_W'(1);
    last_a   = size_m1[OFF_W-1:BW];
    last_b   = start_m1[OFF_W-1:BW];
    iw_last  = iph ? last_b : last_a;
    win_lo   = pph ? '0 : {1'b0, start_q};
    win_hi   = pph ? {1'b0, start_q} : size_q;
  end

  npa_word_search #(.WB(WB), .AW(AW), .OFF_W(OFF_W)) u_search (
    .word    (rdata),
    .widx    (pw),
    .lo      (win_lo),
    .hi      (win_hi),
    .found   (found),
    .bit_idx (bit_idx)
  );

  // bitmap RAM ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [WB-1:0] ram_wdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = off_q[OFF_W-1:BW];
    ram_wdata = wdata_q;
    ram_re    = 1'b0;
    ram_raddr = iw;
    case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      S_REL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = off_q[OFF_W-1:BW];
      end
      S_REL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rdata & ~(WB'(1) << off_q[BW-1:0]);
      end
      S_SCAN: begin
        ram_re = issuing;
      end
      S_ALLOC_WR: begin
        ram_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  npa_ram #(.WIDTH(WB), .DEPTH(NWORDS)) u_used_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  logic [SZ_W-1:0] next_off;
  assign next_off = {1'b0, off_q} + SZ_W'(1);

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      range_low     <= RANGE_LOW_RST;
      range_high    <= RANGE_HIGH_RST;
      search_start  <= RANGE_LOW_RST;
      m_axis_tvalid <= 1'b0;
      issuing       <= 1'b0;
      pend          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_LOW:  range_low  <= cfg_wdata;
          CFG_RANGE_HIGH: range_high <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            size_q  <= SZ_W'(size17);
            start_q <= start_in ? OFF_W'(ss_rel) : '0;
            off_q   <= OFF_W'(port_rel);
            if (s_axis_tuser == FUNC_RELEASE) begin
              res_status <= ST_RELEASED;
              res_port   <= s_axis_tdata;
              state      <= port_in ? S_REL_RD : S_FINISH;
            end else if (empty) begin
              res_status <= ST_EXHAUSTED;
              res_port   <= '0;
              state      <= S_FINISH;
            end else begin
              iw      <= start_in ? ss_rel[OFF_W-1:BW] : '0;
              iph     <= 1'b0;
              issuing <= 1'b1;
              pend    <= 1'b0;
              state   <= S_SCAN;
            end
          end
        end
        S_REL_RD: begin
          state <= S_REL_WR;
        end
        S_REL_WR: begin
          state <= S_FINISH;
        end
        S_SCAN: begin
          pend <= issuing;
          pw   <= iw;
          pph  <= iph;
          if (issuing) begin
            if (iw == iw_last) begin
              if (!iph && (start_q != '0)) begin
                iph <= 1'b1;
                iw  <= '0;
              end else begin
                issuing <= 1'b0;
              end
            end else begin
              iw <= iw + AW'(1);
            end
          end
          if (pend && found) begin
            off_q   <= {pw, bit_idx};
            wdata_q <= rdata | (WB'(1) << bit_idx);
            issuing <= 1'b0;
            pend    <= 1'b0;
            state   <= S_ALLOC_WR;
          end else if (pend && !issuing) begin
            res_status <= ST_EXHAUSTED;
            res_port   <= '0;
            pend       <= 1'b0;
            state      <= S_FINISH;
          end
        end
        S_ALLOC_WR: begin
          res_status   <= ST_GRANTED;
          res_port     <= range_low + 16'(off_q);
          search_start <= range_low + ((next_off == size_q) ? 16'd0 : 16'(next_off));
          state        <= S_FINISH;
        end
        S_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_port;
            m_axis_tuser  <= res_status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/npa_checker.sv
// npa_checker: port-level assertions for next_fit_port_allocator, bound to it.
// Depends on npa_pkg.
module npa_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [15:0] cfg_wdata
);
  import npa_pkg::*;

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && !s_axis_tready)
    else $error("outputs active right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result word changed");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser == ST_GRANTED) || (m_axis_tuser == ST_EXHAUSTED) ||
                      (m_axis_tuser == ST_RELEASED))
    else $error("unknown status code");

  a_exhausted_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_EXHAUSTED) |-> (m_axis_tdata == 16'd0))
    else $error("exhausted result carries a port");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word taken while one is in work");

endmodule

bind next_fit_port_allocator npa_checker u_npa_checker (.*);

FILE: test/npa_reply_checker.sv
// npa_reply_checker: watches the config port and both streams of the port allocator,
// predicts each reply from its own bitmap and pointer, and counts wrong replies.
// Depends on npa_pkg.
module npa_reply_checker #(
  parameter int POOL_SIZE = npa_pkg::POOL_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // release_port_number[15:0]
  input  logic        s_axis_tuser,   // func
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // granted_port[15:0]
  input  logic [1:0]  m_axis_tuser,   // status[1:0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          outstanding
);
  import npa_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] port;
  } reply_t;

  logic [15:0] range_low;
  logic [15:0] range_high;
  logic [15:0] search_ptr;
  bit          port_used[POOL_SIZE];
  reply_t      expected_replies[$];

  function automatic int pool_slots();
    int lo;
    int hi;
    int lim;
    lo = range_low;
    hi = range_high;
    if (hi < lo) return 0;
    lim = lo + POOL_SIZE - 1;
    if (lim > 65535) lim = 65535;
    if (hi > lim) hi = lim;
    return hi - lo + 1;
  endfunction

  function automatic reply_t predict_reply(logic func, logic [15:0] port);
    reply_t r;
    int     slots;
    int     lo;
    int     p;
    int     nx;
    int     start;
    int     off;
    bit     found;
    slots = pool_slots();
    lo    = range_low;
    p     = port;
    if (func == FUNC_RELEASE) begin
      if (slots != 0 && p >= lo && p - lo < slots) port_used[p - lo] = 1'b0;
      r.status = ST_RELEASED;
      r.port   = port;
    end else begin
      r.status = ST_EXHAUSTED;
      r.port   = 16'd0;
      nx       = search_ptr;
      start    = 0;
      found    = 1'b0;
      if (slots != 0 && nx >= lo && nx - lo < slots) start = nx - lo;
      for (int i = 0; i < slots && !found; i++) begin
        off = start + i;
        if (off >= slots) off -= slots;
        if (!port_used[off]) begin
          found          = 1'b1;
          port_used[off] = 1'b1;
          r.status       = ST_GRANTED;
          r.port         = 16'(lo + off);
          search_ptr     = (off + 1 >= slots) ? range_low : 16'(lo + off + 1);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      range_low  = RANGE_LOW_RST;
      range_high = RANGE_HIGH_RST;
      search_ptr = RANGE_LOW_RST;
      port_used  = '{default: 1'b0};
      mismatches = 0;
      expected_replies.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply with none pending: status %0d port %0d", m_axis_tuser,
                     m_axis_tdata);
        end else begin
          want = expected_replies.pop_front();
          if (m_axis_tuser !== want.status || m_axis_tdata !== want.port) begin
            mismatches++;
            if (mismatches <= 10)
              $display("reply mismatch: status %0d/%0d port %0d/%0d (expected/actual)",
                       want.status, m_axis_tuser, want.port, m_axis_tdata);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_RANGE_LOW:  range_low  = cfg_wdata;
          CFG_RANGE_HIGH: range_high = cfg_wdata;
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_replies.push_back(predict_reply(s_axis_tuser, s_axis_tdata));
    end
    outstanding = expected_replies.size();
  end

endmodule

FILE: test/tb_next_fit_port_allocator.sv
// tb_next_fit_port_allocator: drives allocate and release words and range settings
// into the port allocator with random gaps and stalls; npa_reply_checker judges replies.
// Depends on npa_pkg, npa_reply_checker and the allocator RTL.
module tb_next_fit_port_allocator;
  import npa_pkg::*;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // release_port_number[15:0]
  logic        s_axis_tuser;   // func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // granted_port[15:0]
  logic [1:0]  m_axis_tuser;   // status[1:0]
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  int          mismatches;
  int          outstanding;
  bit          steady;
  int          random_words;

  next_fit_port_allocator dut (.*);
  npa_reply_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // hold the word until accepted; return at the falling edge after the handshake
  task automatic send_word(logic func, logic [15:0] port);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= (func == FUNC_ALLOC) ? 16'($urandom()) : port;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    while (!(outstanding == 0 && s_axis_tready)) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic set_range(logic [15:0] lo, logic [15:0] hi);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_RANGE_LOW;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= CFG_RANGE_HIGH;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int run_len;
    m_axis_tready = 1'b0;
    @(negedge clk);
    forever begin
      run_len = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(50, 300);
      m_axis_tready <= 1'b1;
      repeat (run_len) @(negedge clk);
      run_len = pick_gap();
      if (run_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (run_len) @(negedge clk);
      end
    end
  end

  initial begin
    int slots;
    int lo;
    int hi;
    int alloc_pct;
    int phase_words;
    int r;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 16'd0;
    s_axis_tuser  = FUNC_ALLOC;
    cfg_we        = 1'b0;
    cfg_index     = CFG_RANGE_LOW;
    cfg_wdata     = 16'd0;
    steady        = 1'b0;
    random_words  = 0;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // default pool: next-fit order, free-port release, releases outside the pool
    send_word(FUNC_ALLOC, 16'd0);
    send_word(FUNC_ALLOC, 16'd0);
    send_word(FUNC_RELEASE, 16'd10000);
    send_word(FUNC_RELEASE, 16'd10000);
    send_word(FUNC_RELEASE, 16'd0);
    send_word(FUNC_RELEASE, 16'hFFFF);
    send_word(FUNC_RELEASE, 16'd11023);
    send_word(FUNC_ALLOC, 16'd0);

    // pool at the top of the port space; pointer starts outside, old bits kept
    set_range(16'd65533, 16'd65535);
    send_word(FUNC_ALLOC, 16'd0);
    send_word(FUNC_ALLOC, 16'd0);
    send_word(FUNC_RELEASE, 16'd65535);
    send_word(FUNC_ALLOC, 16'd0);
    send_word(FUNC_ALLOC, 16'd0);
    send_word(FUNC_RELEASE, 16'd65534);
    send_word(FUNC_RELEASE, 16'd65533);
    send_word(FUNC_ALLOC, 16'd0);

    // range wider than the bitmap: top clamps to range_low + pool - 1
    set_range(16'd0, 16'd65535);
    send_word(FUNC_ALLOC, 16'd0);
    send_word(FUNC_RELEASE, 16'd1023);
    send_word(FUNC_RELEASE, 16'd1024);
    send_word(FUNC_ALLOC, 16'd0);

    set_range(16'd500, 16'd499);
    send_word(FUNC_ALLOC, 16'd0);
    send_word(FUNC_RELEASE, 16'd500);

    set_range(16'd65535, 16'd65535);
    send_word(FUNC_ALLOC, 16'd0);
    send_word(FUNC_ALLOC, 16'd0);
    send_word(FUNC_RELEASE, 16'd65535);

    while (random_words < 1100) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        slots = 0;
        lo    = $urandom_range(1, 65535);
        hi    = $urandom_range(0, lo - 1);
      end else begin
        if (r < 65)      slots = $urandom_range(1, 40);
        else if (r < 90) slots = $urandom_range(41, 300);
        else             slots = $urandom_range(900, 1100);
        r = $urandom_range(0, 99);
        if (r < 15) begin
          lo = 0;
          hi = slots - 1;
        end else if (r < 30) begin
          lo = 65536 - $urandom_range(1, slots);
          hi = 65535;
        end else begin
          lo = $urandom_range(0, 65535);
          hi = (lo + slots - 1 > 65535) ? 65535 : lo + slots - 1;
        end
      end
      set_range(16'(lo), 16'(hi));
      steady      = ($urandom_range(0, 4) == 0);
      alloc_pct   = $urandom_range(25, 85);
      phase_words = $urandom_range(40, 140);
      repeat (phase_words) begin
        if ($urandom_range(0, 59) == 0) drain();
        if ($urandom_range(0, 99) < alloc_pct)
          send_word(FUNC_ALLOC, 16'd0);
        else if ($urandom_range(0, 99) < 80)
          send_word(FUNC_RELEASE, 16'(lo - 1 + $urandom_range(0, slots + 2)));
        else
          send_word(FUNC_RELEASE, 16'($urandom()));
        random_words++;
      end
    end

    drain();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
